[hdl/teap_pkg.sv]
// shared types, codes and reset values for the tilemap entry attribute packer
`timescale 1ns / 1ps
`default_nettype none

package teap_pkg;

    localparam int TILE_LIMIT_W = 11;
    localparam int MAX_BANKS    = 4;

    typedef enum logic [1:0] {
        FMT_ATTR = 2'd0,
        FMT_WORD = 2'd1,
        FMT_PACK = 2'd2,
        FMT_NONE = 2'd3
    } t_fmt;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_PAL_OFFSET  = 3'd1,
        ERR_TILE_OFFSET = 3'd2,
        ERR_PAL_RANGE   = 3'd3,
        ERR_TILE_RANGE  = 3'd4,
        ERR_BANK_RANGE  = 3'd5
    } t_err;

    localparam logic [2:0] REG_PARAM_FORMAT   = 3'd0;
    localparam logic [2:0] REG_EMIT_INDEX     = 3'd1;
    localparam logic [2:0] REG_PALETTE_OFFSET = 3'd2;
    localparam logic [2:0] REG_TILE_OFFSET    = 3'd3;
    localparam logic [2:0] REG_ADDR_8800_MODE = 3'd4;
    localparam logic [2:0] REG_PALETTE_LIMIT  = 3'd5;
    localparam logic [2:0] REG_TILE_LIMIT     = 3'd6;
    localparam logic [2:0] REG_PALETTE_BASE   = 3'd7;

    localparam logic [7:0]              RST_PALETTE_LIMIT = 8'd8;
    localparam logic [TILE_LIMIT_W-1:0] RST_TILE_LIMIT    = 11'd512;

    typedef struct packed {
        t_fmt                    fmt;
        logic                    emit_index;
        logic [7:0]              palette_offset;
        logic [7:0]              tile_offset;
        logic                    addr_8800_mode;
        logic [7:0]              palette_limit;
        logic [TILE_LIMIT_W-1:0] tile_limit;
        logic [7:0]              palette_base;
    } t_cfg;

    typedef struct packed {
        logic [7:0] tile_num;
        logic [1:0] bank;
        logic [7:0] pal_num;
        logic       hflip;
        logic       vflip;
        logic       priority_req;
        logic       last_entry;
    } t_entry;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic [1:0] pack_slot;
        t_err       error_latched;
    } t_state;

    typedef struct packed {
        logic        index_valid;
        logic [7:0]  index_byte;
        logic        param_valid;
        logic [15:0] param_word;
        t_err        error_code;
    } t_result;

endpackage

`default_nettype wire

[hdl/tilemap_entry_attribute_packer.sv]
// top level: entry register, per-entry logic, packing state and result register
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | i_s_tdata (entry), i_s_tlast (last entry)
//  m       | out | o_m_tvalid/i_m_tready  | o_m_tdata (index, param, error), o_m_tuser
//  cfg     | in  | i_cfg_valid/o_cfg_ready| i_cfg_addr, i_cfg_data
//
// one entry per cycle sustained while m accepts; a beat is taken into the entry register and
// passes through one level of per-entry logic into the result register when it yields a result.
// packing state and the sticky error update as the entry leaves the entry register.
// a stall on m holds the result register and backs up through the entry register to s.
// reset restores configuration defaults and clears packing state and error; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tilemap_entry_attribute_packer #(
    parameter int BANK_TILES = 256,
    parameter int BANK_COUNT = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [7:0] tile_num, [9:8] bank, [17:10] pal_num, [18] hflip,
    // [19] vflip, [20] priority_req, [23:21] zero
    input  wire logic [23:0] i_s_tdata,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [7:0] index_byte, [23:8] param_word, [26:24] error_code, [31:27] zero
    output logic [31:0]      o_m_tdata,
    // [0] index_valid, [1] param_valid
    output logic [1:0]       o_m_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [teap_pkg::TILE_LIMIT_W-1:0] i_cfg_data
);

    teap_pkg::t_cfg    cfg;
    teap_pkg::t_entry  r_entry;
    logic              r_entry_valid;
    teap_pkg::t_state  r_state;
    teap_pkg::t_state  n_state;
    teap_pkg::t_result r_out;
    teap_pkg::t_result n_out;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              has_result;
    logic              advance;

    teap_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    teap_entry_proc #(
        .BANK_TILES (BANK_TILES),
        .BANK_COUNT (BANK_COUNT)
    ) u_proc (
        .i_cfg        (cfg),
        .i_entry      (r_entry),
        .i_state      (r_state),
        .o_has_result (has_result),
        .o_result     (n_out),
        .o_state      (n_state)
    );

    // entry leaves when the result register is free or emptying this cycle
    assign advance     = r_entry_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_entry_valid || advance;
    assign n_out_valid = advance ? has_result : (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '{packed_byte: 8'd0, pack_slot: 2'd0,
                               error_latched: teap_pkg::ERR_NONE};
        end else begin
            if (o_s_tready) begin
                r_entry_valid <= i_s_tvalid;
            end
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_entry.tile_num     <= i_s_tdata[7:0];
            r_entry.bank         <= i_s_tdata[9:8];
            r_entry.pal_num      <= i_s_tdata[17:10];
            r_entry.hflip        <= i_s_tdata[18];
            r_entry.vflip        <= i_s_tdata[19];
            r_entry.priority_req <= i_s_tdata[20];
            r_entry.last_entry   <= i_s_tlast;
        end
        if (advance && has_result) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.error_code, r_out.param_word, r_out.index_byte};
    assign o_m_tuser  = {r_out.param_valid, r_out.index_valid};

    // an error beat never carries data
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != teap_pkg::ERR_NONE)
            |-> (!r_out.index_valid && !r_out.param_valid))
        else $error("error beat carries data");

    // a latched error holds until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.error_latched != teap_pkg::ERR_NONE)
            |=> (r_state.error_latched == $past(r_state.error_latched)))
        else $error("latched error changed");

    // packing state moves only on an entry processed in packed format
    a_pack_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance || cfg.fmt != teap_pkg::FMT_PACK)
            |=> ($stable(r_state.pack_slot) && $stable(r_state.packed_byte)))
        else $error("packing state moved outside packed format");

    // a flush of the packed byte returns the pack slot to zero
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && has_result && cfg.fmt == teap_pkg::FMT_PACK && n_out.param_valid)
            |=> (r_state.pack_slot == 2'd0))
        else $error("pack slot not reset after flush");

endmodule

`default_nettype wire

[hdl/teap_cfg_regs.sv]
// configuration register file, one write per beat
`timescale 1ns / 1ps
`default_nettype none

module teap_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [2:0]                     i_addr,
    input  wire logic [teap_pkg::TILE_LIMIT_W-1:0] i_data,
    output teap_pkg::t_cfg                      o_cfg
);

    teap_pkg::t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt            <= teap_pkg::FMT_ATTR;
            r_cfg.emit_index     <= 1'b1;
            r_cfg.palette_offset <= '0;
            r_cfg.tile_offset    <= '0;
            r_cfg.addr_8800_mode <= 1'b0;
            r_cfg.palette_limit  <= teap_pkg::RST_PALETTE_LIMIT;
            r_cfg.tile_limit     <= teap_pkg::RST_TILE_LIMIT;
            r_cfg.palette_base   <= '0;
        end else if (i_valid) begin
            unique case (i_addr)
                teap_pkg::REG_PARAM_FORMAT:   r_cfg.fmt <= teap_pkg::t_fmt'(i_data[1:0]);
                teap_pkg::REG_EMIT_INDEX:     r_cfg.emit_index <= i_data[0];
                teap_pkg::REG_PALETTE_OFFSET: r_cfg.palette_offset <= i_data[7:0];
                teap_pkg::REG_TILE_OFFSET:    r_cfg.tile_offset <= i_data[7:0];
                teap_pkg::REG_ADDR_8800_MODE: r_cfg.addr_8800_mode <= i_data[0];
                teap_pkg::REG_PALETTE_LIMIT:  r_cfg.palette_limit <= i_data[7:0];
                teap_pkg::REG_TILE_LIMIT:     r_cfg.tile_limit <= i_data;
                teap_pkg::REG_PALETTE_BASE:   r_cfg.palette_base <= i_data[7:0];
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/teap_entry_proc.sv]
// per-entry checks, tile rebasing and parameter formatting
`timescale 1ns / 1ps
`default_nettype none

module teap_entry_proc #(
    parameter int BANK_TILES = 256,
    parameter int BANK_COUNT = 2
) (
    input  teap_pkg::t_cfg    i_cfg,
    input  teap_pkg::t_entry  i_entry,
    input  teap_pkg::t_state  i_state,
    output logic              o_has_result,
    output teap_pkg::t_result o_result,
    output teap_pkg::t_state  o_state
);

    // wide enough for every bank threshold and the largest rebased index
    localparam int GW = $clog2(teap_pkg::MAX_BANKS * BANK_TILES + 512);
    localparam int CW = (GW > teap_pkg::TILE_LIMIT_W) ? GW : teap_pkg::TILE_LIMIT_W;

    always_comb begin
        logic [8:0]      pal_sum;
        logic [GW-1:0]   global_idx;
        logic [CW-1:0]   global_ext;
        logic [CW-1:0]   toff_ext;
        logic [2:0]      bank_q;
        logic [GW-1:0]   bank_rem;
        logic [7:0]      tile;
        logic [1:0]      bank;
        logic [7:0]      pal;
        logic            pvalid;
        logic [15:0]     pword;
        logic [7:0]      packed_or;
        teap_pkg::t_err  err;

        pal_sum    = {1'b0, i_entry.pal_num} + {1'b0, i_cfg.palette_offset};
        global_idx = GW'(i_entry.tile_num) + GW'(i_entry.bank) * GW'(BANK_TILES)
                   + GW'(i_cfg.tile_offset);
        global_ext = CW'(global_idx);
        toff_ext   = CW'(i_cfg.tile_offset);

        // bank split by threshold compares against constant multiples
        bank_q = 3'd0;
        for (int k = 1; k <= teap_pkg::MAX_BANKS; k++) begin
            if (global_idx >= GW'(k * BANK_TILES)) begin
                bank_q = bank_q + 3'd1;
            end
        end
        bank_rem = global_idx - GW'(bank_q) * GW'(BANK_TILES);

        priority if (i_cfg.palette_offset >= i_cfg.palette_limit) begin
            err = teap_pkg::ERR_PAL_OFFSET;
        end else if (toff_ext >= CW'(i_cfg.tile_limit)) begin
            err = teap_pkg::ERR_TILE_OFFSET;
        end else if (pal_sum >= {1'b0, i_cfg.palette_limit}) begin
            err = teap_pkg::ERR_PAL_RANGE;
        end else if (i_cfg.tile_offset != 8'd0 && global_ext >= CW'(i_cfg.tile_limit)) begin
            err = teap_pkg::ERR_TILE_RANGE;
        end else if (i_cfg.tile_offset != 8'd0 && bank_q >= 3'(BANK_COUNT)) begin
            err = teap_pkg::ERR_BANK_RANGE;
        end else begin
            err = teap_pkg::ERR_NONE;
        end

        if (i_cfg.tile_offset != 8'd0) begin
            tile = bank_rem[7:0];
            bank = bank_q[1:0];
        end else begin
            tile = i_entry.tile_num;
            bank = i_entry.bank;
        end
        // adding 128 with 8-bit wrap only flips the top bit
        if (i_cfg.addr_8800_mode) begin
            tile = {~tile[7], tile[6:0]};
        end

        pal       = pal_sum[7:0] + i_cfg.palette_base;
        pvalid    = 1'b0;
        pword     = '0;
        packed_or = i_state.packed_byte;
        o_state   = i_state;

        unique case (i_state.pack_slot)
            2'd0: packed_or[7:6] = i_state.packed_byte[7:6] | pal[1:0];
            2'd1: packed_or[5:4] = i_state.packed_byte[5:4] | pal[1:0];
            2'd2: packed_or[3:2] = i_state.packed_byte[3:2] | pal[1:0];
            2'd3: packed_or[1:0] = i_state.packed_byte[1:0] | pal[1:0];
        endcase

        unique case (i_cfg.fmt)
            teap_pkg::FMT_ATTR: begin
                pvalid = 1'b1;
                pword  = {8'd0, i_entry.priority_req, i_entry.vflip,
                          i_entry.hflip, 1'b0, bank[0], pal[2:0]};
            end
            teap_pkg::FMT_WORD: begin
                pvalid = 1'b1;
                pword  = {i_entry.vflip, i_entry.hflip, 2'b00,
                          pal[1:0], 2'b00, tile};
            end
            teap_pkg::FMT_PACK: begin
                if (i_state.pack_slot == 2'd3 || i_entry.last_entry) begin
                    pvalid              = 1'b1;
                    pword               = {8'd0, packed_or};
                    o_state.packed_byte = '0;
                    o_state.pack_slot   = 2'd0;
                end else begin
                    o_state.packed_byte = packed_or;
                    o_state.pack_slot   = i_state.pack_slot + 2'd1;
                end
            end
            teap_pkg::FMT_NONE: begin
                pvalid = 1'b0;
            end
        endcase

        o_result.index_valid = i_cfg.emit_index;
        o_result.index_byte  = i_cfg.emit_index ? tile : 8'd0;
        o_result.param_valid = pvalid;
        o_result.param_word  = pword;
        o_result.error_code  = teap_pkg::ERR_NONE;
        o_has_result         = i_cfg.emit_index || pvalid;

        // sticky error: report it and leave the packing state alone
        if (i_state.error_latched != teap_pkg::ERR_NONE || err != teap_pkg::ERR_NONE) begin
            o_state              = i_state;
            o_has_result         = 1'b1;
            o_result.index_valid = 1'b0;
            o_result.index_byte  = '0;
            o_result.param_valid = 1'b0;
            o_result.param_word  = '0;
            if (i_state.error_latched != teap_pkg::ERR_NONE) begin
                o_result.error_code = i_state.error_latched;
            end else begin
                o_result.error_code    = err;
                o_state.error_latched  = err;
            end
        end
    end

endmodule

`default_nettype wire
